// ===== design/lcdseq_pkg.sv =====
// lcdseq_pkg: shared types, codes and sequence tables for the display bus sequencer
package lcdseq_pkg;

   // field widths
   localparam int ACTION_W = 3;
   localparam int COL_W    = 6;
   localparam int CHAR_W   = 8;
   localparam int NIB_W    = 4;
   localparam int STATUS_W = 2;
   localparam int PHASE_W  = 6;
   localparam int TIMER_W  = 16;
   localparam int PULSE_W  = 8;

   // configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INIT  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POS   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_TICK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ACCEPTED   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_REF_BUSY   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_REF_RANGE  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_EN_PULSE   = 3'd0;
   localparam logic [2:0] REG_CMD_DELAY  = 3'd1;
   localparam logic [2:0] REG_LONG_DELAY = 3'd2;
   localparam logic [2:0] REG_POWER_ON   = 3'd3;
   localparam logic [2:0] REG_WAKE_FIRST = 3'd4;
   localparam logic [2:0] REG_WAKE       = 3'd5;

   // register reset values
   localparam logic [PULSE_W-1:0] RST_EN_PULSE   = 8'd2;
   localparam logic [TIMER_W-1:0] RST_CMD_DELAY  = 16'd50;
   localparam logic [TIMER_W-1:0] RST_LONG_DELAY = 16'd2000;
   localparam logic [TIMER_W-1:0] RST_POWER_ON   = 16'd50000;
   localparam logic [TIMER_W-1:0] RST_WAKE_FIRST = 16'd5000;
   localparam logic [TIMER_W-1:0] RST_WAKE       = 16'd150;

   // sequence entry points
   localparam logic [PHASE_W-1:0] PHASE_IDLE  = 6'd0;
   localparam logic [PHASE_W-1:0] ENTRY_INIT  = 6'd1;
   localparam logic [PHASE_W-1:0] ENTRY_CLEAR = 6'd34;
   localparam logic [PHASE_W-1:0] ENTRY_BYTE  = 6'd41;

   // display address command bits
   localparam logic [CHAR_W-1:0] CMD_SET_ADDR = 8'h80;
   localparam logic [CHAR_W-1:0] ROW1_BASE    = 8'h40;

   typedef enum logic [3:0] {
      K_POWER,
      K_NIB,
      K_LOW,
      K_WAKE1,
      K_WAKE,
      K_CMD,
      K_BYTE,
      K_LOWN,
      K_CMDW,
      K_LONG,
      K_END
   } seq_kind_type;

   typedef struct packed {
      logic [PULSE_W-1:0] en_pulse_ticks;
      logic [TIMER_W-1:0] cmd_delay_ticks;
      logic [TIMER_W-1:0] long_delay_ticks;
      logic [TIMER_W-1:0] power_on_ticks;
      logic [TIMER_W-1:0] wake_first_ticks;
      logic [TIMER_W-1:0] wake_ticks;
   } lcdseq_cfg_type;

   // kind of each step of the sequence table
   function automatic seq_kind_type seq_kind(input logic [PHASE_W-1:0] ph);
      seq_kind_type k;
      unique case (ph)
         6'd1:                                   k = K_POWER;
         6'd2, 6'd5, 6'd8, 6'd11:                k = K_NIB;
         6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd17,
         6'd20, 6'd22, 6'd25, 6'd27, 6'd30,
         6'd32, 6'd35, 6'd37, 6'd42, 6'd44:      k = K_LOW;
         6'd4:                                   k = K_WAKE1;
         6'd7, 6'd10, 6'd13:                     k = K_WAKE;
         6'd14, 6'd19, 6'd24, 6'd29, 6'd34:      k = K_CMD;
         6'd16, 6'd21, 6'd26, 6'd31, 6'd36,
         6'd43:                                  k = K_LOWN;
         6'd18, 6'd23, 6'd28, 6'd33, 6'd38,
         6'd45:                                  k = K_CMDW;
         6'd39:                                  k = K_LONG;
         6'd41:                                  k = K_BYTE;
         default:                                k = K_END;
      endcase
      return k;
   endfunction

   // fixed nibble or command byte of each step
   function automatic logic [CHAR_W-1:0] seq_value(input logic [PHASE_W-1:0] ph);
      logic [CHAR_W-1:0] v;
      unique case (ph)
         6'd2, 6'd5, 6'd8: v = 8'h03;
         6'd11:            v = 8'h02;
         6'd14:            v = 8'h28;
         6'd19:            v = 8'h08;
         6'd24:            v = 8'h0C;
         6'd29:            v = 8'h06;
         6'd34:            v = 8'h01;
         default:          v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

// ===== design/lcdseq_if.sv =====
// lcdseq_if: request and response channel interfaces of the display bus sequencer

// request channel
interface lcdseq_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic       row;
   logic [5:0] col;
   logic [7:0] char_code;

   modport source (output valid, output action, output row, output col, output char_code,
                   input ready);
   modport sink   (input valid, input action, input row, input col, input char_code,
                   output ready);
endinterface

// response channel
interface lcdseq_rsp_if;
   logic       valid;
   logic       ready;
   logic       rs_line;
   logic       en_line;
   logic [3:0] bus_nibble;
   logic       busy_flag;
   logic [1:0] status;

   modport source (output valid, output rs_line, output en_line, output bus_nibble,
                   output busy_flag, output status, input ready);
   modport sink   (input valid, input rs_line, input en_line, input bus_nibble,
                   input busy_flag, input status, output ready);
endinterface

// ===== design/lcdseq_csr.sv =====
// lcdseq_csr: timing register file behind the apb-style configuration port
module lcdseq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcdseq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lcdseq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lcdseq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready,
   output lcdseq_pkg::lcdseq_cfg_type          cfg
);
   import lcdseq_pkg::*;

   lcdseq_cfg_type cfg_ff;
   logic [2:0]     reg_index;
   logic           wr_fire;

   assign reg_index  = csr_paddr[4:2];
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.en_pulse_ticks   <= RST_EN_PULSE;
         cfg_ff.cmd_delay_ticks  <= RST_CMD_DELAY;
         cfg_ff.long_delay_ticks <= RST_LONG_DELAY;
         cfg_ff.power_on_ticks   <= RST_POWER_ON;
         cfg_ff.wake_first_ticks <= RST_WAKE_FIRST;
         cfg_ff.wake_ticks       <= RST_WAKE;
      end else if (wr_fire) begin
         case (reg_index)
            REG_EN_PULSE:   cfg_ff.en_pulse_ticks   <= csr_pwdata[PULSE_W-1:0];
            REG_CMD_DELAY:  cfg_ff.cmd_delay_ticks  <= csr_pwdata[TIMER_W-1:0];
            REG_LONG_DELAY: cfg_ff.long_delay_ticks <= csr_pwdata[TIMER_W-1:0];
            REG_POWER_ON:   cfg_ff.power_on_ticks   <= csr_pwdata[TIMER_W-1:0];
            REG_WAKE_FIRST: cfg_ff.wake_first_ticks <= csr_pwdata[TIMER_W-1:0];
            REG_WAKE:       cfg_ff.wake_ticks       <= csr_pwdata[TIMER_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         REG_EN_PULSE:   csr_prdata = CSR_DATA_W'(cfg_ff.en_pulse_ticks);
         REG_CMD_DELAY:  csr_prdata = CSR_DATA_W'(cfg_ff.cmd_delay_ticks);
         REG_LONG_DELAY: csr_prdata = CSR_DATA_W'(cfg_ff.long_delay_ticks);
         REG_POWER_ON:   csr_prdata = CSR_DATA_W'(cfg_ff.power_on_ticks);
         REG_WAKE_FIRST: csr_prdata = CSR_DATA_W'(cfg_ff.wake_first_ticks);
         REG_WAKE:       csr_prdata = CSR_DATA_W'(cfg_ff.wake_ticks);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// ===== design/char_lcd_nibble_interface_sequencer.sv =====
// char_lcd_nibble_interface_sequencer: 4-bit character display bus sequencer, top level
// The response to an item is registered and valid in the cycle after the item is taken.
// Throughput: one item per cycle while the response side is ready, since a waiting
// response does not hold the next item; step and tick counter update in one pass.
// Reset (synchronous, active high) idles the sequencer with all lines low, loads the
// default timing registers and marks the cursor column as unset.
module char_lcd_nibble_interface_sequencer #(
   parameter int COLUMNS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   lcdseq_req_if.sink                          req_chan,
   lcdseq_rsp_if.source                        rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lcdseq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lcdseq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lcdseq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import lcdseq_pkg::*;

   localparam int CNT_W = $clog2(COLUMNS + 1) < 1 ? 1 : $clog2(COLUMNS + 1);

   lcdseq_cfg_type     cfg;

   // sequencer state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [CHAR_W-1:0]  pend_ff, pend_in;
   logic               rs_ff, rs_in;
   logic               en_ff, en_in;
   logic [NIB_W-1:0]   nib_ff, nib_in;
   logic [CNT_W-1:0]   ccount_ff, ccount_in;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_rs_ff;
   logic                rsp_en_ff;
   logic [NIB_W-1:0]    rsp_nib_ff;
   logic                rsp_busy_ff;
   logic [STATUS_W-1:0] rsp_status_ff, status_in;

   logic               in_fire;
   logic               is_request;
   logic               step_enter;
   seq_kind_type       step_kind;
   logic [CHAR_W-1:0]  step_value;
   logic [CHAR_W-1:0]  pos_byte;

   lcdseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: take an item whenever the response slot is free or being drained
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign in_fire        = req_chan.valid & req_chan.ready;

   assign is_request = (req_chan.action == ACT_INIT) || (req_chan.action == ACT_CLEAR) ||
                       (req_chan.action == ACT_POS)  || (req_chan.action == ACT_WRITE);

   // set-address command for the requested row and column
   assign pos_byte = CMD_SET_ADDR | (req_chan.row ? ROW1_BASE : 8'h00) |
                     CHAR_W'(req_chan.col);

   // next state for one item
   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      pend_in    = pend_ff;
      rs_in      = rs_ff;
      en_in      = en_ff;
      nib_in     = nib_ff;
      ccount_in  = ccount_ff;
      status_in  = STAT_TICK;
      step_enter = 1'b0;

      // tick or request decode
      if (!is_request) begin
         if (phase_ff != PHASE_IDLE) begin
            if (timer_ff > 16'd1) begin
               timer_in = timer_ff - 16'd1;
            end else begin
               phase_in   = phase_ff + 6'd1;
               step_enter = 1'b1;
            end
         end
      end else if (phase_ff != PHASE_IDLE) begin
         status_in = STAT_REF_BUSY;
      end else begin
         case (req_chan.action)
            ACT_INIT: begin
               phase_in   = ENTRY_INIT;
               step_enter = 1'b1;
               status_in  = STAT_ACCEPTED;
            end
            ACT_CLEAR: begin
               phase_in   = ENTRY_CLEAR;
               step_enter = 1'b1;
               status_in  = STAT_ACCEPTED;
            end
            ACT_POS: begin
               if (7'(req_chan.col) >= 7'(COLUMNS)) begin
                  status_in = STAT_REF_RANGE;
               end else begin
                  pend_in    = pos_byte;
                  rs_in      = 1'b0;
                  ccount_in  = CNT_W'(req_chan.col);
                  phase_in   = ENTRY_BYTE;
                  step_enter = 1'b1;
                  status_in  = STAT_ACCEPTED;
               end
            end
            default: begin
               // write character
               if (ccount_ff >= CNT_W'(COLUMNS)) begin
                  status_in = STAT_REF_RANGE;
               end else begin
                  pend_in    = req_chan.char_code;
                  rs_in      = 1'b1;
                  ccount_in  = ccount_ff + CNT_W'(1);
                  phase_in   = ENTRY_BYTE;
                  step_enter = 1'b1;
                  status_in  = STAT_ACCEPTED;
               end
            end
         endcase
      end

      // kind and fixed value of the step being entered
      step_kind  = seq_kind(phase_in);
      step_value = seq_value(phase_in);

      // start of a new step
      if (step_enter) begin
         unique case (step_kind)
            K_POWER: begin
               rs_in    = 1'b0;
               en_in    = 1'b0;
               timer_in = cfg.power_on_ticks;
            end
            K_NIB: begin
               rs_in    = 1'b0;
               en_in    = 1'b1;
               nib_in   = step_value[NIB_W-1:0];
               timer_in = TIMER_W'(cfg.en_pulse_ticks);
            end
            K_LOW: begin
               en_in    = 1'b0;
               timer_in = TIMER_W'(cfg.en_pulse_ticks);
            end
            K_WAKE1: begin
               en_in    = 1'b0;
               timer_in = cfg.wake_first_ticks;
            end
            K_WAKE: begin
               en_in    = 1'b0;
               timer_in = cfg.wake_ticks;
            end
            K_CMD: begin
               pend_in  = step_value;
               rs_in    = 1'b0;
               en_in    = 1'b1;
               nib_in   = step_value[CHAR_W-1:NIB_W];
               timer_in = TIMER_W'(cfg.en_pulse_ticks);
            end
            K_BYTE: begin
               en_in    = 1'b1;
               nib_in   = pend_in[CHAR_W-1:NIB_W];
               timer_in = TIMER_W'(cfg.en_pulse_ticks);
            end
            K_LOWN: begin
               en_in    = 1'b1;
               nib_in   = pend_in[NIB_W-1:0];
               timer_in = TIMER_W'(cfg.en_pulse_ticks);
            end
            K_CMDW: begin
               en_in    = 1'b0;
               timer_in = cfg.cmd_delay_ticks;
            end
            K_LONG: begin
               en_in    = 1'b0;
               timer_in = cfg.long_delay_ticks;
            end
            default: begin
               // end of sequence
               phase_in = PHASE_IDLE;
               en_in    = 1'b0;
               timer_in = '0;
            end
         endcase
      end
   end

   // sequencer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_IDLE;
         timer_ff  <= '0;
         pend_ff   <= '0;
         rs_ff     <= 1'b0;
         en_ff     <= 1'b0;
         nib_ff    <= '0;
         ccount_ff <= CNT_W'(COLUMNS);
      end else if (in_fire) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         pend_ff   <= pend_in;
         rs_ff     <= rs_in;
         en_ff     <= en_in;
         nib_ff    <= nib_in;
         ccount_ff <= ccount_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (in_fire) begin
         rsp_rs_ff     <= rs_in;
         rsp_en_ff     <= en_in;
         rsp_nib_ff    <= nib_in;
         rsp_busy_ff   <= (phase_in != PHASE_IDLE);
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.rs_line    = rsp_rs_ff;
   assign rsp_chan.en_line    = rsp_en_ff;
   assign rsp_chan.bus_nibble = rsp_nib_ff;
   assign rsp_chan.busy_flag  = rsp_busy_ff;
   assign rsp_chan.status     = rsp_status_ff;

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for the character display nibble bus sequencer
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdseq_pkg::*;

   localparam int COLUMNS         = 16;
   localparam int STEP_COUNT      = 47;
   localparam int MAX_GAP         = 17;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [ACTION_W-1:0] ACT_LAST = '1;

   // pin levels and status carried by one result item
   typedef struct {
      logic             rs;
      logic             en;
      logic [NIB_W-1:0] nibble;
      logic             busy;
      logic [1:0]       status;
   } pin_levels_type;

   // tracks the sequencer and holds the pin levels each accepted item should produce
   class pin_scoreboard_type;
      logic [PULSE_W-1:0] en_pulse;
      logic [TIMER_W-1:0] cmd_delay;
      logic [TIMER_W-1:0] long_delay;
      logic [TIMER_W-1:0] power_on;
      logic [TIMER_W-1:0] wake_first;
      logic [TIMER_W-1:0] wake_rest;
      logic [PHASE_W-1:0] step;
      logic [TIMER_W-1:0] ticks_left;
      logic [CHAR_W-1:0]  out_byte;
      logic               rs_q;
      logic               en_q;
      logic [NIB_W-1:0]   nibble_q;
      logic [6:0]         column;
      pin_levels_type     expected_pins[$];
      int                 mismatches;
      int                 results_seen;

      function new();
         en_pulse     = RST_EN_PULSE;
         cmd_delay    = RST_CMD_DELAY;
         long_delay   = RST_LONG_DELAY;
         power_on     = RST_POWER_ON;
         wake_first   = RST_WAKE_FIRST;
         wake_rest    = RST_WAKE;
         step         = PHASE_IDLE;
         ticks_left   = '0;
         out_byte     = '0;
         rs_q         = 1'b0;
         en_q         = 1'b0;
         nibble_q     = '0;
         column       = 7'(COLUMNS);
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void load_reg(input logic [2:0] idx, input logic [31:0] value);
         case (idx)
            REG_EN_PULSE:   en_pulse   = value[PULSE_W-1:0];
            REG_CMD_DELAY:  cmd_delay  = value[TIMER_W-1:0];
            REG_LONG_DELAY: long_delay = value[TIMER_W-1:0];
            REG_POWER_ON:   power_on   = value[TIMER_W-1:0];
            REG_WAKE_FIRST: wake_first = value[TIMER_W-1:0];
            REG_WAKE:       wake_rest  = value[TIMER_W-1:0];
            default: ;
         endcase
      endfunction

      // init commands, in the order they go out (the last one is the clear)
      function logic [CHAR_W-1:0] init_command(input int n);
         case (n)
            0:       return 8'h28;
            1:       return 8'h08;
            2:       return 8'h0C;
            3:       return 8'h06;
            default: return 8'h01;
         endcase
      endfunction

      // what a step of the sequence does, from its position
      function seq_kind_type kind_of(input int p);
         if (p == ENTRY_INIT) return K_POWER;
         // three wake-up nibbles and the 4-bit switch: pulse, low, wait
         if (p >= 2 && p <= 13) begin
            case ((p - 2) % 3)
               0:       return K_NIB;
               1:       return K_LOW;
               default: return (p == 4) ? K_WAKE1 : K_WAKE;
            endcase
         end
         // full command bytes: high pulse, low, low nibble pulse, low, wait
         if (p >= 14 && p <= 38) begin
            case ((p - 14) % 5)
               0:       return K_CMD;
               2:       return K_LOWN;
               4:       return K_CMDW;
               default: return K_LOW;
            endcase
         end
         if (p == 39) return K_LONG;
         if (p >= ENTRY_BYTE && p <= ENTRY_BYTE + 4) begin
            case (p - ENTRY_BYTE)
               0:       return K_BYTE;
               2:       return K_LOWN;
               4:       return K_CMDW;
               default: return K_LOW;
            endcase
         end
         return K_END;
      endfunction

      function void enter_step();
         int           p;
         seq_kind_type k;
         p = step;
         k = (step == PHASE_IDLE || p >= STEP_COUNT) ? K_END : kind_of(p);
         case (k)
            K_POWER: begin
               rs_q = 1'b0; en_q = 1'b0; ticks_left = power_on;
            end
            K_NIB: begin
               rs_q = 1'b0; en_q = 1'b1; ticks_left = TIMER_W'(en_pulse);
               nibble_q = (p == 11) ? 4'h2 : 4'h3;
            end
            K_LOW: begin
               en_q = 1'b0; ticks_left = TIMER_W'(en_pulse);
            end
            K_WAKE1: begin
               en_q = 1'b0; ticks_left = wake_first;
            end
            K_WAKE: begin
               en_q = 1'b0; ticks_left = wake_rest;
            end
            K_CMD: begin
               out_byte = init_command((p - 14) / 5);
               rs_q = 1'b0; en_q = 1'b1; nibble_q = out_byte[7:4];
               ticks_left = TIMER_W'(en_pulse);
            end
            K_BYTE: begin
               en_q = 1'b1; nibble_q = out_byte[7:4]; ticks_left = TIMER_W'(en_pulse);
            end
            K_LOWN: begin
               en_q = 1'b1; nibble_q = out_byte[3:0]; ticks_left = TIMER_W'(en_pulse);
            end
            K_CMDW: begin
               en_q = 1'b0; ticks_left = cmd_delay;
            end
            K_LONG: begin
               en_q = 1'b0; ticks_left = long_delay;
            end
            default: begin
               step = PHASE_IDLE; en_q = 1'b0; ticks_left = '0;
            end
         endcase
      endfunction

      // a zero count behaves like one tick
      function void count_tick();
         if (step == PHASE_IDLE) return;
         if (ticks_left > 1) begin
            ticks_left--;
         end else begin
            step++;
            enter_step();
         end
      endfunction

      function void launch(input logic [PHASE_W-1:0] entry);
         step = entry;
         enter_step();
      endfunction

      function bit busy();
         return step != PHASE_IDLE;
      endfunction

      function int outstanding();
         return expected_pins.size();
      endfunction

      // apply one accepted item and queue the pin levels it leaves behind
      function void note_item(input logic [ACTION_W-1:0] act, input logic r,
                              input logic [COL_W-1:0] c, input logic [CHAR_W-1:0] chr);
         logic [1:0]     st;
         pin_levels_type want;
         st = STAT_TICK;
         if (act == ACT_TICK || act > ACT_WRITE) begin
            count_tick();
         end else if (step != PHASE_IDLE) begin
            st = STAT_REF_BUSY;
         end else begin
            case (act)
               ACT_INIT: begin
                  launch(ENTRY_INIT);
                  st = STAT_ACCEPTED;
               end
               ACT_CLEAR: begin
                  launch(ENTRY_CLEAR);
                  st = STAT_ACCEPTED;
               end
               ACT_POS: begin
                  if (c >= COLUMNS) begin
                     st = STAT_REF_RANGE;
                  end else begin
                     out_byte = CMD_SET_ADDR | (r ? ROW1_BASE : '0) | {2'b00, c};
                     rs_q = 1'b0;
                     column = {1'b0, c};
                     launch(ENTRY_BYTE);
                     st = STAT_ACCEPTED;
                  end
               end
               default: begin
                  // line full also covers a cursor that was never placed
                  if (column >= COLUMNS) begin
                     st = STAT_REF_RANGE;
                  end else begin
                     out_byte = chr;
                     rs_q = 1'b1;
                     column = column + 7'd1;
                     launch(ENTRY_BYTE);
                     st = STAT_ACCEPTED;
                  end
               end
            endcase
         end
         want.rs     = rs_q;
         want.en     = en_q;
         want.nibble = nibble_q;
         want.busy   = (step != PHASE_IDLE);
         want.status = st;
         expected_pins.push_back(want);
      endfunction

      // compare one result item against the oldest expectation
      function void check_pins(input pin_levels_type got);
         pin_levels_type want;
         results_seen++;
         if (expected_pins.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d with no item pending: rs=%0d en=%0d nibble=%h busy=%0d status=%0d",
                        results_seen, got.rs, got.en, got.nibble, got.busy, got.status);
            return;
         end
         want = expected_pins.pop_front();
         if (got.rs !== want.rs || got.en !== want.en || got.nibble !== want.nibble ||
             got.busy !== want.busy || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result %0d: expected rs=%0d en=%0d nibble=%h busy=%0d status=%0d, got rs=%0d en=%0d nibble=%h busy=%0d status=%0d",
                        results_seen, want.rs, want.en, want.nibble, want.busy, want.status,
                        got.rs, got.en, got.nibble, got.busy, got.status);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   bit                    no_gaps = 1'b0;
   bit                    stall_rsp = 1'b0;
   int                    cycle_count = 0;
   pin_scoreboard_type    board = new();

   lcdseq_req_if req_chan ();
   lcdseq_rsp_if rsp_chan ();

   char_lcd_nibble_interface_sequencer #(
      .COLUMNS(COLUMNS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 12 ns clock
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("char_lcd_nibble_interface_sequencer: mismatch");
         $finish;
      end
   end

   // offer one item after a random gap and wait for it to be taken
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic r,
                            input logic [COL_W-1:0] c, input logic [CHAR_W-1:0] chr);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.action    <= act;
      req_chan.row       <= r;
      req_chan.col       <= c;
      req_chan.char_code <= chr;
      do @(posedge clock); while (!req_chan.ready);
      board.note_item(act, r, c, chr);
   endtask

   // mostly ticks while busy, mostly requests while idle; fields always random
   task automatic send_random_item();
      int                  pick;
      logic [ACTION_W-1:0] act;
      logic [COL_W-1:0]    c;
      pick = $urandom_range(0, 99);
      c = 6'($urandom_range(0, 63));
      if (board.busy()) begin
         if (pick < 80) act = ACT_TICK;
         else if (pick < 86) act = 3'($urandom_range(ACT_WRITE + 1, ACT_LAST));
         else act = 3'($urandom_range(ACT_INIT, ACT_WRITE));
      end else begin
         if (pick < 6) begin
            act = ACT_TICK;
         end else if (pick < 9) begin
            act = 3'($urandom_range(ACT_WRITE + 1, ACT_LAST));
         end else if (pick < 13) begin
            act = ACT_INIT;
         end else if (pick < 22) begin
            act = ACT_CLEAR;
         end else if (pick < 55) begin
            act = ACT_POS;
            if ($urandom_range(0, 3) != 0) c = 6'($urandom_range(0, COLUMNS - 1));
         end else begin
            act = ACT_WRITE;
         end
      end
      send_item(act, 1'($urandom_range(0, 1)), c, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_items(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 4) == 0);
         send_random_item();
      end
      no_gaps = 1'b0;
   endtask

   // tick until the running sequence is over
   task automatic tick_until_idle();
      while (board.busy())
         send_item(ACT_TICK, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                   8'($urandom_range(0, 255)));
   endtask

   // finish the sequence and collect every result before touching registers
   task automatic settle();
      tick_until_idle();
      req_chan.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_timing_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.load_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_timing(input int pulse, input int cmd, input int lng,
                                 input int pwr, input int first, input int rest);
      write_timing_reg(REG_EN_PULSE, pulse);
      write_timing_reg(REG_CMD_DELAY, cmd);
      write_timing_reg(REG_LONG_DELAY, lng);
      write_timing_reg(REG_POWER_ON, pwr);
      write_timing_reg(REG_WAKE_FIRST, first);
      write_timing_reg(REG_WAKE, rest);
   endtask

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int             gap;
      pin_levels_type got;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (stall_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            stall_rsp = 1'b0;
         end
         gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.rs     = rsp_chan.rs_line;
         got.en     = rsp_chan.en_line;
         got.nibble = rsp_chan.bus_nibble;
         got.busy   = rsp_chan.busy_flag;
         got.status = rsp_chan.status;
         board.check_pins(got);
      end
   end

   // stimulus
   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.action    <= ACT_TICK;
      req_chan.row       <= 1'b0;
      req_chan.col       <= '0;
      req_chan.char_code <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      reset              <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing: idle ticks, unknown actions, range refusals
      send_item(ACT_TICK, 1'b0, 6'd0, 8'h00);
      for (int a = ACT_WRITE + 1; a <= ACT_LAST; a++)
         send_item(3'(a), 1'b1, 6'd63, 8'hFF);
      send_item(ACT_WRITE, 1'b0, 6'd0, 8'hA5);
      send_item(ACT_POS, 1'b0, 6'(COLUMNS), 8'h00);
      send_item(ACT_POS, 1'b1, 6'd63, 8'h00);
      // last column on row 1, then requests while busy (busy wins over range)
      send_item(ACT_POS, 1'b1, 6'(COLUMNS - 1), 8'h00);
      send_item(ACT_INIT, 1'b0, 6'd0, 8'h00);
      send_item(ACT_CLEAR, 1'b0, 6'd0, 8'h00);
      send_item(ACT_WRITE, 1'b0, 6'd0, 8'h41);
      send_item(ACT_POS, 1'b0, 6'd63, 8'h00);
      send_item(ACT_LAST, 1'b0, 6'd0, 8'h00);
      no_gaps = 1'b1;
      tick_until_idle();
      // last character of the line, then the line is full
      send_item(ACT_WRITE, 1'b0, 6'd0, 8'hFF);
      tick_until_idle();
      no_gaps = 1'b0;
      send_item(ACT_WRITE, 1'b1, 6'd0, 8'h00);
      settle();

      // shortest timing, zero counts on two registers
      program_timing(1, 1, 0, 1, 0, 1);
      send_item(ACT_INIT, 1'b0, 6'd0, 8'h00);
      tick_until_idle();
      send_item(ACT_CLEAR, 1'b0, 6'd0, 8'h00);
      tick_until_idle();
      send_item(ACT_POS, 1'b0, 6'd0, 8'h00);
      tick_until_idle();
      send_item(ACT_WRITE, 1'b0, 6'd0, 8'h00);
      tick_until_idle();
      send_item(ACT_WRITE, 1'b0, 6'd0, 8'hFF);
      send_random_items(300);
      settle();

      // small random timing, result side held off to back up the input
      program_timing($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 10),
                     $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 5));
      stall_rsp = 1'b1;
      send_random_items(300);
      settle();

      program_timing($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 20),
                     $urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 8));
      send_random_items(250);
      settle();

      // widest pulse and longest waits; the run ends partway through the first pulse
      program_timing(255, 65535, 65535, 65535, 65535, 65535);
      send_item(ACT_POS, 1'b1, 6'd7, 8'h00);
      send_random_items(50);

      req_chan.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("char_lcd_nibble_interface_sequencer: match");
      else
         $display("char_lcd_nibble_interface_sequencer: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
design/lcdseq_pkg.sv
design/lcdseq_if.sv
design/lcdseq_csr.sv
design/char_lcd_nibble_interface_sequencer.sv
test/testbench.sv
